// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
// Define ASSERT_OFF to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked check that is switched off while reset is asserted.
`define SUKT_ASSERT(name, clk, rstn, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Clocked check that also holds during reset.
`define SUKT_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SUKT_ASSERT(name, clk, rstn, prop, msg)
`define SUKT_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// ===== rtl/core/sukt_pkg.sv =====
package sukt_pkg;

    // Fixed field widths of the transaction channels.
    localparam int KEY_W   = 32;
    localparam int POS_W   = 6;
    localparam int COUNT_W = 7;

    // Operation codes carried on the input channel.
    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_DELETE = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_CLEAR  = 2'd3
    } mode_t;

    // Result status codes.
    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_FULL = 2'd1,
        STATUS_MISS = 2'd2
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic rd_mid;
        logic cmp;
        logic shift_ins_start;
        logic shift_del_start;
        logic shift_rd;
        logic shift_wr;
        logic put_key;
        logic cnt_inc;
        logic cnt_dec;
        logic cnt_clr;
        logic set_full;
        logic set_miss;
        logic load_out;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        mode_t mode;
        logic  search_done;
        logic  found;
        logic  full;
        logic  shift_done;
        logic  out_free;
    } dp_stat_t;

endpackage

// ===== rtl/core/sorted_unique_key_table_top.sv =====
// Channel  Direction  Handshake          Payload
// s_       input      s_valid / s_ready  s_mode, s_key
// m_       output     m_valid / m_ready  m_status, m_position, m_count
//
// One transaction is worked at a time; s_ready is high only while the block is idle.
// Clear and insert into a full table finish without touching the key memory; search, delete and
// insert run a binary search on the key memory's one read port, then a delete that removes a key
// or an insert that adds one moves entries with one read and one write each, and the insert writes the key.
// Reset is synchronous and active low; it empties the table, with no clearing pass.
// The last cycle stalls only while the previous result still waits in the output register.
module sorted_unique_key_table_top #(
    parameter int DEPTH = 64
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  sukt_pkg::mode_t                    s_mode,
    input  logic signed [sukt_pkg::KEY_W-1:0]  s_key,
    output logic                               m_valid,
    input  logic                               m_ready,
    output sukt_pkg::status_t                  m_status,
    output logic [sukt_pkg::POS_W-1:0]         m_position,
    output logic [sukt_pkg::COUNT_W-1:0]       m_count
);

    import sukt_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    sukt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Key memory, search window and result register.
    sukt_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_mode    (s_mode),
        .in_key     (s_key),
        .cmd        (cmd),
        .stat       (stat),
        .m_ready    (m_ready),
        .m_valid    (m_valid),
        .m_status   (m_status),
        .m_position (m_position),
        .m_count    (m_count)
    );

endmodule

// ===== rtl/core/sukt_ram.sv =====
module sukt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AddrW-1:0] wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AddrW-1:0] rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/sukt_dp.sv =====
`include "assert_macros.svh"

module sukt_dp #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  sukt_pkg::mode_t                     in_mode,
    input  logic signed [sukt_pkg::KEY_W-1:0]   in_key,
    input  sukt_pkg::dp_cmd_t                   cmd,
    output sukt_pkg::dp_stat_t                  stat,
    input  logic                                m_ready,
    output logic                                m_valid,
    output sukt_pkg::status_t                   m_status,
    output logic [sukt_pkg::POS_W-1:0]          m_position,
    output logic [sukt_pkg::COUNT_W-1:0]        m_count
);

    import sukt_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    // Operation registers.
    mode_t              mode_reg;
    logic signed [KEY_W-1:0] key_reg;
    status_t            status_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      lo_reg, lo_next;
    logic [CW-1:0]      hi_reg, hi_next;
    logic               eq_reg, eq_next;
    logic [CW-1:0]      idx_reg, idx_next;

    // Output register.
    logic               m_valid_reg;
    status_t            m_status_reg;
    logic [POS_W-1:0]   m_position_reg;
    logic [COUNT_W-1:0] m_count_reg;

    // Memory port signals.
    logic               ram_wr_en;
    logic [AW-1:0]      ram_wr_addr;
    logic [KEY_W-1:0]   ram_wr_data;
    logic               ram_rd_en;
    logic [AW-1:0]      ram_rd_addr;
    logic [KEY_W-1:0]   ram_rd_data;

    logic [CW:0]        mid_sum;
    logic [CW-1:0]      mid;
    logic [CW-1:0]      idx_dn;
    logic [CW-1:0]      idx_up;
    logic               rd_less;
    logic [31:0]        lo_ext;
    logic [31:0]        count_ext;

    // Midpoint of the open search window and the shift neighbors.
    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = mid_sum[CW:1];
    assign idx_dn  = idx_reg - CW'(1);
    assign idx_up  = idx_reg + CW'(1);
    assign rd_less = $signed(ram_rd_data) < key_reg;

    // Memory port selection.
    always_comb begin
        ram_rd_en   = cmd.rd_mid | cmd.shift_rd;
        ram_rd_addr = mid[AW-1:0];
        if (cmd.shift_rd) begin
            ram_rd_addr = (mode_reg == MODE_INSERT) ? idx_dn[AW-1:0] : idx_up[AW-1:0];
        end
        ram_wr_en   = cmd.shift_wr | cmd.put_key;
        ram_wr_addr = idx_reg[AW-1:0];
        ram_wr_data = ram_rd_data;
        if (cmd.put_key) begin
            ram_wr_addr = lo_reg[AW-1:0];
            ram_wr_data = key_reg;
        end
    end

    sukt_ram #(
        .WIDTH (KEY_W),
        .DEPTH (DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Search window, match flag, shift index and key count.
    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        eq_next    = eq_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        if (cmd.capture) begin
            lo_next = '0;
            hi_next = count_reg;
            eq_next = 1'b0;
        end
        if (cmd.cmp) begin
            if (rd_less) begin
                lo_next = mid + CW'(1);
            end else begin
                hi_next = mid;
                eq_next = (ram_rd_data == key_reg);
            end
        end
        if (cmd.shift_ins_start) begin
            idx_next = count_reg;
        end
        if (cmd.shift_del_start) begin
            idx_next = lo_reg;
        end
        if (cmd.shift_wr) begin
            idx_next = (mode_reg == MODE_INSERT) ? idx_dn : idx_up;
        end
        if (cmd.cnt_inc) begin
            count_next = count_reg + CW'(1);
        end
        if (cmd.cnt_dec) begin
            count_next = count_reg - CW'(1);
        end
        if (cmd.cnt_clr) begin
            count_next = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign lo_ext    = 32'(lo_reg);
    assign count_ext = 32'(count_reg);

    // Payload registers.
    always_ff @(posedge aclk) begin
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        eq_reg  <= eq_next;
        idx_reg <= idx_next;
        if (cmd.capture) begin
            mode_reg   <= in_mode;
            key_reg    <= in_key;
            status_reg <= STATUS_OK;
        end else if (cmd.set_full) begin
            status_reg <= STATUS_FULL;
        end else if (cmd.set_miss) begin
            status_reg <= STATUS_MISS;
        end
        if (cmd.load_out) begin
            m_status_reg   <= status_reg;
            m_position_reg <= (mode_reg == MODE_SEARCH && status_reg == STATUS_OK) ?
                              lo_ext[POS_W-1:0] : '0;
            m_count_reg    <= count_ext[COUNT_W-1:0];
        end
    end

    // Status toward the controller.
    always_comb begin
        stat.mode        = mode_reg;
        stat.search_done = (lo_reg == hi_reg);
        stat.found       = eq_reg;
        stat.full        = (count_reg == CW'(DEPTH));
        stat.out_free    = !m_valid_reg || m_ready;
        if (mode_reg == MODE_INSERT) begin
            stat.shift_done = (idx_reg == lo_reg);
        end else begin
            stat.shift_done = ({1'b0, idx_reg} + (CW+1)'(1)) >= {1'b0, count_reg};
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_status   = m_status_reg;
    assign m_position = m_position_reg;
    assign m_count    = m_count_reg;

    `SUKT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= CW'(DEPTH), "key count above depth")
    `SUKT_ASSERT(a_put_not_full, aclk, aresetn, cmd.put_key |-> !stat.full, "insert into full table")
    `SUKT_ASSERT(a_dec_nonzero, aclk, aresetn, cmd.cnt_dec |-> count_reg != '0, "delete from empty table")
    `SUKT_ASSERT(a_clr_empties, aclk, aresetn, cmd.cnt_clr |=> count_reg == '0, "clear left keys counted")
    `SUKT_ASSERT(a_load_shows, aclk, aresetn, cmd.load_out |=> m_valid_reg, "loaded result not shown")

endmodule

// ===== rtl/core/sukt_ctrl.sv =====
`include "assert_macros.svh"

module sukt_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  sukt_pkg::dp_stat_t stat,
    output sukt_pkg::dp_cmd_t  cmd
);

    import sukt_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DECIDE   = 9'b000000010,
        ST_SRCH_RD  = 9'b000000100,
        ST_SRCH_CMP = 9'b000001000,
        ST_CHECK    = 9'b000010000,
        ST_SHIFT_RD = 9'b000100000,
        ST_SHIFT_WR = 9'b001000000,
        ST_PUT      = 9'b010000000,
        ST_DONE     = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (stat.mode == MODE_CLEAR) begin
                    cmd.cnt_clr = 1'b1;
                    state_next  = ST_DONE;
                end else if (stat.mode == MODE_INSERT && stat.full) begin
                    cmd.set_full = 1'b1;
                    state_next   = ST_DONE;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                if (stat.search_done) begin
                    state_next = ST_CHECK;
                end else begin
                    cmd.rd_mid = 1'b1;
                    state_next = ST_SRCH_CMP;
                end
            end
            ST_SRCH_CMP: begin
                cmd.cmp    = 1'b1;
                state_next = ST_SRCH_RD;
            end
            ST_CHECK: begin
                if (stat.mode == MODE_INSERT) begin
                    if (stat.found) begin
                        state_next = ST_DONE;
                    end else begin
                        cmd.shift_ins_start = 1'b1;
                        state_next          = ST_SHIFT_RD;
                    end
                end else if (!stat.found) begin
                    cmd.set_miss = 1'b1;
                    state_next   = ST_DONE;
                end else if (stat.mode == MODE_DELETE) begin
                    cmd.shift_del_start = 1'b1;
                    state_next          = ST_SHIFT_RD;
                end else begin
                    state_next = ST_DONE;
                end
            end
            ST_SHIFT_RD: begin
                if (stat.shift_done) begin
                    if (stat.mode == MODE_INSERT) begin
                        state_next = ST_PUT;
                    end else begin
                        cmd.cnt_dec = 1'b1;
                        state_next  = ST_DONE;
                    end
                end else begin
                    cmd.shift_rd = 1'b1;
                    state_next   = ST_SHIFT_WR;
                end
            end
            ST_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = ST_SHIFT_RD;
            end
            ST_PUT: begin
                cmd.put_key = 1'b1;
                cmd.cnt_inc = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    `SUKT_ASSERT(a_cmp_after_rd, aclk, aresetn, state_reg == ST_SRCH_CMP |-> $past(cmd.rd_mid), "compare without a read")
    `SUKT_ASSERT(a_wr_after_rd, aclk, aresetn, cmd.shift_wr |-> $past(cmd.shift_rd), "shift write without a read")
    `SUKT_ASSERT(a_load_free, aclk, aresetn, cmd.load_out |-> stat.out_free, "result loaded over a waiting one")
    `SUKT_ASSERT(a_put_insert, aclk, aresetn, cmd.put_key |-> stat.mode == MODE_INSERT, "key written outside insert")

endmodule

// ===== test/key_table_sb_pkg.sv =====
package key_table_sb_pkg;
    import sukt_pkg::*;

    localparam int TABLE_DEPTH = 64;

    // One result transaction as the block should produce it.
    typedef struct packed {
        status_t              status;
        logic [POS_W-1:0]     position;
        logic [COUNT_W-1:0]   count;
    } table_response_t;

    class key_table_scoreboard;
        // Shadow copy of the sorted table; only entries below held_count are valid.
        logic [KEY_W-1:0]  held_keys [TABLE_DEPTH];
        int unsigned       held_count;
        table_response_t   expected_q [$];
        int                mismatches;
        int unsigned       result_index;

        function new();
            held_count   = 0;
            mismatches   = 0;
            result_index = 0;
        endfunction

        function void report_mismatch(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endfunction

        // Apply one operation to the shadow table and return the result it gives.
        function table_response_t apply_operation(mode_t mode, logic [KEY_W-1:0] key);
            table_response_t rsp;
            int unsigned     slot;
            int unsigned     idx;
            bit              hit;
            rsp.status   = STATUS_OK;
            rsp.position = '0;
            // Lower bound under signed ordering.
            slot = 0;
            while (slot < held_count && $signed(held_keys[slot]) < $signed(key)) begin
                slot++;
            end
            hit = (slot < held_count) && (held_keys[slot] == key);
            case (mode)
                MODE_INSERT: begin
                    // The full check wins even over a duplicate key.
                    if (held_count >= TABLE_DEPTH) begin
                        rsp.status = STATUS_FULL;
                    end else if (!hit) begin
                        for (idx = held_count; idx > slot; idx--) begin
                            held_keys[idx] = held_keys[idx-1];
                        end
                        held_keys[slot] = key;
                        held_count++;
                    end
                end
                MODE_DELETE: begin
                    if (!hit) begin
                        rsp.status = STATUS_MISS;
                    end else begin
                        for (idx = slot; idx + 1 < held_count; idx++) begin
                            held_keys[idx] = held_keys[idx+1];
                        end
                        held_count--;
                    end
                end
                MODE_SEARCH: begin
                    if (hit) begin
                        rsp.position = slot[POS_W-1:0];
                    end else begin
                        rsp.status = STATUS_MISS;
                    end
                end
                default: begin
                    // Clear keeps the stored keys but no longer counts them.
                    held_count = 0;
                end
            endcase
            rsp.count = held_count[COUNT_W-1:0];
            return rsp;
        endfunction

        // Called for every accepted input transaction.
        function void note_request(mode_t mode, logic [KEY_W-1:0] key);
            expected_q.push_back(apply_operation(mode, key));
        endfunction

        // Called for every accepted result transaction.
        function void check_result(status_t status, logic [POS_W-1:0] position,
                                   logic [COUNT_W-1:0] count);
            table_response_t exp;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with nothing expected",
                                          result_index));
            end else begin
                exp = expected_q.pop_front();
                if (status !== exp.status) begin
                    report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                              result_index, status, exp.status));
                end
                if (position !== exp.position) begin
                    report_mismatch($sformatf("result %0d position %0d, expected %0d",
                                              result_index, position, exp.position));
                end
                if (count !== exp.count) begin
                    report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                              result_index, count, exp.count));
                end
            end
            result_index++;
        endfunction
    endclass

endpackage

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sukt_pkg::*;
    import key_table_sb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int DRAIN_CYCLES  = 200;
    localparam int PHASE_ITEMS   = 430;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    mode_t                     s_mode = MODE_INSERT;
    logic signed [KEY_W-1:0]   s_key = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    status_t                   m_status;
    logic [POS_W-1:0]          m_position;
    logic [COUNT_W-1:0]        m_count;

    int unsigned send_idle_pct = 7;
    int unsigned recv_idle_pct = 56;
    int unsigned cycle_count = 0;
    bit          draining = 1'b0;

    key_table_scoreboard sb = new();

    sorted_unique_key_table_top #(
        .DEPTH(TABLE_DEPTH)
    ) DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_key      (s_key),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_position (m_position),
        .m_count    (m_count)
    );

    always #2 aclk = ~aclk;

    // Random backpressure on the result side, changed away from the sampling edge.
    always @(negedge aclk) begin
        m_ready = aresetn && ($urandom_range(99) >= recv_idle_pct);
    end

    // Both channels are observed at the rising edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                sb.note_request(s_mode, s_key);
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_status, m_position, m_count);
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Present one input transaction and hold it until it is taken.
    task automatic send_op(mode_t mode, logic [KEY_W-1:0] key);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_mode  = mode;
        s_key   = key;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
    endtask

    // Keys lean toward ones already held so that hits and duplicates are common.
    function automatic logic [KEY_W-1:0] pick_key();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 45 && sb.held_count > 0) begin
            return sb.held_keys[$urandom_range(sb.held_count - 1)];
        end else if (sel < 75) begin
            return $urandom();
        end else if (sel < 90) begin
            return $urandom_range(40) - 20;
        end
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h8000_0001;
            2: return 32'h7fff_ffff;
            3: return 32'h7fff_fffe;
            4: return 32'hffff_ffff;
            default: return 32'h0000_0000;
        endcase
    endfunction

    // Alternate between filling the table up to full and draining it back down.
    task automatic send_random();
        int unsigned sel;
        mode_t       mode;
        if (!draining && sb.held_count >= TABLE_DEPTH && $urandom_range(9) == 0) begin
            draining = 1'b1;
        end else if (draining && sb.held_count < 4) begin
            draining = 1'b0;
        end
        sel = $urandom_range(99);
        if (sel < 2) begin
            mode = MODE_CLEAR;
        end else if (sel < 30) begin
            mode = MODE_SEARCH;
        end else if (sel < (draining ? 50 : 88)) begin
            mode = MODE_INSERT;
        end else begin
            mode = MODE_DELETE;
        end
        send_op(mode, pick_key());
    endtask

    initial begin
        int phase;
        int n;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed: empty table, key extremes, duplicates, misses and clear.
        send_op(MODE_SEARCH, 32'h0000_0000);
        send_op(MODE_DELETE, 32'h0000_0005);
        send_op(MODE_INSERT, 32'h0000_0000);
        send_op(MODE_INSERT, 32'h7fff_ffff);
        send_op(MODE_INSERT, 32'h8000_0000);
        send_op(MODE_INSERT, 32'hffff_ffff);
        send_op(MODE_INSERT, 32'h0000_0001);
        send_op(MODE_INSERT, 32'h0000_0000);
        send_op(MODE_SEARCH, 32'h8000_0000);
        send_op(MODE_SEARCH, 32'h7fff_ffff);
        send_op(MODE_SEARCH, 32'h0000_0002);
        send_op(MODE_SEARCH, 32'hffff_ffff);
        send_op(MODE_DELETE, 32'h0000_0000);
        send_op(MODE_DELETE, 32'h0000_0000);
        send_op(MODE_SEARCH, 32'h0000_0001);
        send_op(MODE_CLEAR,  32'h0000_0000);
        send_op(MODE_SEARCH, 32'h0000_0001);
        send_op(MODE_INSERT, 32'h5555_5555);
        send_op(MODE_INSERT, 32'haaaa_aaaa);
        send_op(MODE_DELETE, 32'haaaa_aaaa);
        send_op(MODE_CLEAR,  32'hffff_ffff);

        // Random: three idling profiles, the last with no idling at all.
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 7;
                    recv_idle_pct = 56;
                end
                1: begin
                    send_idle_pct = 56;
                    recv_idle_pct = 7;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_random();
            end
        end
        s_valid = 1'b0;

        // Let every outstanding result come back, then allow for stragglers.
        while (sb.expected_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (sb.expected_q.size() != 0) begin
            sb.report_mismatch($sformatf("%0d results never arrived", sb.expected_q.size()));
        end
        if (sb.mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
